// ===== rtl/fss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Fair-share slot scheduler package
// Shared widths, codes, the nice-to-weight table and the control and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package fss_pkg;

  localparam int NUM_SLOTS_DEF = 64;
  localparam int SLOT_IN_W     = 6;
  localparam int NICE_IN_W     = 8;
  localparam int NICE_W        = 6;
  localparam int VR_W          = 31;
  localparam int LEN_W         = 8;
  localparam int LAT_W         = 10;
  localparam int WGT_W         = 17;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 10;
  // A charge divides used*1024, which fits in 18 bits.
  localparam int CHG_STEPS     = 18;

  typedef enum logic [1:0] {
    REQ_TICK     = 2'd0,
    REQ_RUNNABLE = 2'd1,
    REQ_NICE     = 2'd2,
    REQ_CLEAR    = 2'd3
  } req_t;

  localparam logic [CFG_IDX_W-1:0] CFG_LATENCY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN     = 2'd2;

  typedef enum logic [1:0] {
    ADDR_SLOT = 2'd0,
    ADDR_CUR  = 2'd1,
    ADDR_SCAN = 2'd2
  } addr_sel_t;

  typedef struct packed {
    logic      latch;
    addr_sel_t addr_sel;
    logic      tick;
    logic      ch_start;
    logic      ch_wr;
    logic      scan_clr;
    logic      scan_step;
    logic      mul;
    logic      gr_start;
    logic      grant;
    logic      nt_apply;
    logic      res_none;
    logic      load_out;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic cont;
    logic has_cur;
    logic div_busy;
    logic scan_done;
    logic found;
    logic out_free;
  } sts_t;

  localparam logic [WGT_W-1:0] WEIGHT_TAB [40] = '{
    17'd88761, 17'd71755, 17'd56483, 17'd46273, 17'd36291,
    17'd29154, 17'd23254, 17'd18705, 17'd14949, 17'd11916,
    17'd9548,  17'd7620,  17'd6100,  17'd4904,  17'd3906,
    17'd3121,  17'd2501,  17'd1991,  17'd1586,  17'd1277,
    17'd1024,  17'd820,   17'd655,   17'd526,   17'd423,
    17'd335,   17'd272,   17'd215,   17'd172,   17'd137,
    17'd110,   17'd87,    17'd70,    17'd56,    17'd45,
    17'd36,    17'd29,    17'd23,    17'd18,    17'd15
  };

  // Weight of a nice value, clamped to the table range.
  function automatic logic [WGT_W-1:0] weight_of(input logic signed [NICE_W-1:0] n);
    logic signed [NICE_W-1:0] c;
    logic [5:0]               k;
    c = n;
    if (n < -6'sd20) c = -6'sd20;
    else if (n > 6'sd19) c = 6'sd19;
    k = 6'(c + 6'sd20);
    return WEIGHT_TAB[k];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/fss_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write first in program order; the read returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/fss_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Radix-2 restoring divider
// Produces one quotient bit per cycle over a chosen number of steps, taking
// the dividend left-aligned.
// ----------------------------------------------------------------------------
module fss_div #(
  parameter int DVD_W = 28,
  parameter int DVS_W = 23
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [DVD_W-1:0]           dividend,
  input  logic [DVS_W-1:0]           divisor,
  input  logic [$clog2(DVD_W+1)-1:0] steps,
  output logic                       busy,
  output logic [DVD_W-1:0]           quotient
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              busy_r;
  logic [STEP_W-1:0] cnt_r;
  logic [DVS_W:0]    rem_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [DVD_W-1:0]  quo_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVS_W:0]    shifted;
  logic [DVS_W+1:0]  trial;
  logic              ge;

  // One trial subtraction per cycle.
  assign shifted = {rem_r[DVS_W-1:0], dvd_r[DVD_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_r};
  assign ge      = ~trial[DVS_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= steps;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      quo_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? trial[DVS_W:0] : shifted;
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      quo_r <= {quo_r[DVD_W-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ===== rtl/fss_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler datapath
// Slot table, configuration, slice counters, the scan for the minimum
// virtual runtime and weight sum, the divider and the result registers.
// ----------------------------------------------------------------------------
module fss_datapath #(
  parameter int NUM_SLOTS = fss_pkg::NUM_SLOTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [1:0]                           in_req_type,
  input  logic [fss_pkg::SLOT_IN_W-1:0]        in_slot,
  input  logic                                 in_runnable_in,
  input  logic signed [fss_pkg::NICE_IN_W-1:0] in_nice_in,
  input  logic                                 cfg_wr_en,
  input  logic [fss_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fss_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  fss_pkg::cmd_t                        cmd,
  output fss_pkg::sts_t                        sts,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic                                 out_run_valid,
  output logic [fss_pkg::SLOT_IN_W-1:0]        out_run_slot,
  output logic                                 out_new_pick,
  output logic [fss_pkg::LEN_W-1:0]            out_slice_len,
  output logic signed [fss_pkg::NICE_W-1:0]    out_nice_now
);

  import fss_pkg::*;

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int SX_W   = (SLOT_W > SLOT_IN_W) ? SLOT_W : SLOT_IN_W;
  localparam int SUM_W  = WGT_W + SLOT_W;
  localparam int PROD_W = LAT_W + WGT_W;
  localparam int DVD_W  = ((PROD_W > SUM_W) ? PROD_W : SUM_W) + 1;
  localparam int STEP_W = $clog2(DVD_W + 1);

  // Request registers.
  req_t                        req_r;
  logic [SLOT_IN_W-1:0]        slot_r;
  logic                        run_r;
  logic signed [NICE_IN_W-1:0] nice_in_r;

  // Configuration.
  logic [LAT_W-1:0] lat_r;
  logic [LEN_W-1:0] max_r;
  logic [LEN_W-1:0] min_r;

  // Slot table flags and valid bits.
  logic [NUM_SLOTS-1:0] flags_r;
  logic [NUM_SLOTS-1:0] nvld_r;
  logic [NUM_SLOTS-1:0] vvld_r;

  // Current task.
  logic [SLOT_W-1:0] cur_r;
  logic              has_cur_r;
  logic [LEN_W-1:0]  granted_r;
  logic [LEN_W-1:0]  left_r;

  // Scan state.
  logic [CNT_W-1:0]         idx_r;
  logic                     pvalid_r;
  logic [SUM_W-1:0]         sum_r;
  logic                     found_r;
  logic [SLOT_W-1:0]        best_r;
  logic [VR_W-1:0]          best_vr_r;
  logic signed [NICE_W-1:0] best_nice_r;

  logic [VR_W-1:0]   vr_cur_r;
  logic [PROD_W-1:0] prod_r;

  // Pending result.
  logic                     res_valid_r;
  logic [SLOT_IN_W-1:0]     res_slot_r;
  logic                     res_new_r;
  logic [LEN_W-1:0]         res_len_r;
  logic signed [NICE_W-1:0] res_nice_r;

  // Output register.
  logic                     out_valid_r;
  logic                     out_run_valid_r;
  logic [SLOT_IN_W-1:0]     out_run_slot_r;
  logic                     out_new_pick_r;
  logic [LEN_W-1:0]         out_slice_len_r;
  logic signed [NICE_W-1:0] out_nice_now_r;

  // Memory access.
  logic [SLOT_W-1:0]        rd_addr;
  logic [SLOT_W-1:0]        rd_idx_r;
  logic [NICE_W-1:0]        nice_q;
  logic [VR_W-1:0]          vr_q;
  logic signed [NICE_W-1:0] nice_eff;
  logic [VR_W-1:0]          vr_eff;
  logic                     nice_we;
  logic [VR_W-1:0]          vr_new;

  // Derived values.
  logic [SX_W-1:0]   slot_x;
  logic [SLOT_W-1:0] slot_idx;
  logic              s_ok;
  logic              nice_ok;
  logic [LEN_W-1:0]  left_dec;
  logic              cont;
  logic [LEN_W-1:0]  used;
  logic [WGT_W-1:0]  w_eff;
  logic [CHG_STEPS-1:0] inc;
  logic [VR_W:0]     vr_sum;
  logic [LEN_W-1:0]  len_clamp;
  logic              scan_done;

  // Divider.
  logic              div_start;
  logic [DVD_W-1:0]  div_dvd;
  logic [SUM_W-1:0]  div_dvs;
  logic [STEP_W-1:0] div_steps;
  logic              div_busy;
  logic [DVD_W-1:0]  div_q;

  assign slot_x   = SX_W'(slot_r);
  assign slot_idx = slot_x[SLOT_W-1:0];
  assign s_ok     = {1'b0, slot_x} < (SX_W+1)'(NUM_SLOTS);
  assign nice_ok  = (nice_in_r >= -8'sd20) && (nice_in_r <= 8'sd19);

  // Read address selection for both table memories.
  always_comb begin
    case (cmd.addr_sel)
      ADDR_SLOT: rd_addr = slot_idx;
      ADDR_CUR:  rd_addr = cur_r;
      ADDR_SCAN: rd_addr = idx_r[SLOT_W-1:0];
      default:   rd_addr = slot_idx;
    endcase
  end

  // An entry never written since reset or clear reads as zero.
  assign nice_eff = nvld_r[rd_idx_r] ? $signed(nice_q) : '0;
  assign vr_eff   = vvld_r[rd_idx_r] ? vr_q : '0;
  assign w_eff    = weight_of(nice_eff);

  assign nice_we = cmd.nt_apply && (req_r == REQ_NICE) && s_ok && nice_ok;

  fss_ram #(.WIDTH(NICE_W), .DEPTH(NUM_SLOTS)) u_nice_ram (
    .clk   (clk),
    .we    (nice_we),
    .waddr (slot_idx),
    .wdata (nice_in_r[NICE_W-1:0]),
    .raddr (rd_addr),
    .rdata (nice_q)
  );

  fss_ram #(.WIDTH(VR_W), .DEPTH(NUM_SLOTS)) u_vr_ram (
    .clk   (clk),
    .we    (cmd.ch_wr),
    .waddr (cur_r),
    .wdata (vr_new),
    .raddr (rd_addr),
    .rdata (vr_q)
  );

  // Tick bookkeeping: the slice counter stops at zero.
  assign left_dec = (left_r == '0) ? '0 : left_r - 1'b1;
  assign cont     = has_cur_r && (left_dec != '0) && flags_r[cur_r];
  assign used     = granted_r - left_r;

  // Charge: at least one, runtime saturates at its top value.
  assign inc    = (div_q[CHG_STEPS-1:0] == '0) ? CHG_STEPS'(1) : div_q[CHG_STEPS-1:0];
  assign vr_sum = {1'b0, vr_cur_r} + (VR_W+1)'(inc);
  assign vr_new = vr_sum[VR_W] ? {VR_W{1'b1}} : vr_sum[VR_W-1:0];

  // Grant clamp: max first, then min wins.
  always_comb begin
    len_clamp = (div_q > DVD_W'(max_r)) ? max_r : div_q[LEN_W-1:0];
    if (len_clamp < min_r) len_clamp = min_r;
  end

  assign scan_done = (idx_r == CNT_W'(NUM_SLOTS)) && !pvalid_r;

  // Divider operands: charge or grant division.
  assign div_start = cmd.ch_start || cmd.gr_start;
  always_comb begin
    if (cmd.ch_start) begin
      div_dvd   = {used, 10'b0, (DVD_W-CHG_STEPS)'(0)};
      div_dvs   = SUM_W'(w_eff);
      div_steps = STEP_W'(CHG_STEPS);
    end else begin
      div_dvd   = DVD_W'(prod_r) + DVD_W'(sum_r) - DVD_W'(1);
      div_dvs   = sum_r;
      div_steps = STEP_W'(DVD_W);
    end
  end

  fss_div #(.DVD_W(DVD_W), .DVS_W(SUM_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .steps    (div_steps),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // Request capture and the read index tracking.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r     <= req_t'(in_req_type);
      slot_r    <= in_slot;
      run_r     <= in_runnable_in;
      nice_in_r <= in_nice_in;
    end
    rd_idx_r <= rd_addr;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_r <= LAT_W'(100);
      max_r <= LEN_W'(10);
      min_r <= LEN_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_LATENCY: lat_r <= cfg_wdata;
        CFG_MAX:     max_r <= cfg_wdata[LEN_W-1:0];
        CFG_MIN:     min_r <= cfg_wdata[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Slot flags, valid bits and the current task.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r   <= '0;
      nvld_r    <= '0;
      vvld_r    <= '0;
      cur_r     <= '0;
      has_cur_r <= 1'b0;
      granted_r <= '0;
      left_r    <= '0;
    end else begin
      if (cmd.tick) begin
        left_r <= left_dec;
      end
      if (cmd.ch_wr) begin
        vvld_r[cur_r] <= 1'b1;
        has_cur_r     <= 1'b0;
      end
      if (cmd.grant) begin
        cur_r     <= best_r;
        has_cur_r <= 1'b1;
        granted_r <= len_clamp;
        left_r    <= len_clamp;
      end
      if (cmd.nt_apply && s_ok) begin
        case (req_r)
          REQ_RUNNABLE: flags_r[slot_idx] <= run_r;
          REQ_NICE: begin
            if (nice_ok) nvld_r[slot_idx] <= 1'b1;
          end
          REQ_CLEAR: begin
            flags_r[slot_idx] <= 1'b0;
            nvld_r[slot_idx]  <= 1'b0;
            vvld_r[slot_idx]  <= 1'b0;
            if (has_cur_r && (cur_r == slot_idx)) begin
              has_cur_r <= 1'b0;
              left_r    <= '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Scan over all slots, one per cycle, behind the registered memory read.
  always_ff @(posedge clk) begin
    if (cmd.ch_start) begin
      vr_cur_r <= vr_eff;
    end
    if (cmd.scan_clr) begin
      idx_r    <= '0;
      pvalid_r <= 1'b0;
      sum_r    <= '0;
      found_r  <= 1'b0;
    end else if (cmd.scan_step) begin
      if (idx_r != CNT_W'(NUM_SLOTS)) begin
        idx_r    <= idx_r + 1'b1;
        pvalid_r <= 1'b1;
      end else begin
        pvalid_r <= 1'b0;
      end
      if (pvalid_r && flags_r[rd_idx_r]) begin
        sum_r <= sum_r + SUM_W'(w_eff);
        if (!found_r || (vr_eff < best_vr_r)) begin
          found_r     <= 1'b1;
          best_r      <= rd_idx_r;
          best_vr_r   <= vr_eff;
          best_nice_r <= nice_eff;
        end
      end
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(lat_r) * PROD_W'(weight_of(best_nice_r));
    end
  end

  // Pending result.
  always_ff @(posedge clk) begin
    if (cmd.tick && cont) begin
      res_valid_r <= 1'b1;
      res_slot_r  <= SLOT_IN_W'(cur_r);
      res_new_r   <= 1'b0;
      res_len_r   <= granted_r;
      res_nice_r  <= '0;
    end else if (cmd.res_none) begin
      res_valid_r <= 1'b0;
      res_slot_r  <= '0;
      res_new_r   <= 1'b0;
      res_len_r   <= '0;
      res_nice_r  <= '0;
    end else if (cmd.grant) begin
      res_valid_r <= 1'b1;
      res_slot_r  <= SLOT_IN_W'(best_r);
      res_new_r   <= 1'b1;
      res_len_r   <= len_clamp;
      res_nice_r  <= '0;
    end else if (cmd.nt_apply) begin
      res_valid_r <= 1'b0;
      res_slot_r  <= '0;
      res_new_r   <= 1'b0;
      res_len_r   <= '0;
      if (!s_ok || (req_r == REQ_CLEAR)) begin
        res_nice_r <= '0;
      end else if ((req_r == REQ_NICE) && nice_ok) begin
        res_nice_r <= nice_in_r[NICE_W-1:0];
      end else begin
        res_nice_r <= nice_eff;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_run_valid_r <= res_valid_r;
      out_run_slot_r  <= res_slot_r;
      out_new_pick_r  <= res_new_r;
      out_slice_len_r <= res_len_r;
      out_nice_now_r  <= res_nice_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_run_valid = out_run_valid_r;
  assign out_run_slot  = out_run_slot_r;
  assign out_new_pick  = out_new_pick_r;
  assign out_slice_len = out_slice_len_r;
  assign out_nice_now  = out_nice_now_r;

  // Status to the controller.
  assign sts.is_tick   = (req_r == REQ_TICK);
  assign sts.cont      = cont;
  assign sts.has_cur   = has_cur_r;
  assign sts.div_busy  = div_busy;
  assign sts.scan_done = scan_done;
  assign sts.found     = found_r;
  assign sts.out_free  = !out_valid_r || !out_stall;

endmodule
`default_nettype wire

// ===== rtl/fss_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences one request at a time: table updates, tick bookkeeping, the
// charge, the slot scan, the grant division and the result hand-off.
// ----------------------------------------------------------------------------
module fss_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  fss_pkg::sts_t sts,
  output fss_pkg::cmd_t cmd
);

  import fss_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_NT_APPLY,
    ST_TICK,
    ST_CH_RD,
    ST_CH_DIV,
    ST_CH_WR,
    ST_SCAN,
    ST_MUL,
    ST_GR_START,
    ST_GR_DIV,
    ST_GRANT,
    ST_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_stall_r;

  // Next state and commands.
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.addr_sel = ADDR_SLOT;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmd.addr_sel = ADDR_SLOT;
        state_nxt    = sts.is_tick ? ST_TICK : ST_NT_APPLY;
      end
      ST_NT_APPLY: begin
        cmd.nt_apply = 1'b1;
        state_nxt    = ST_OUT;
      end
      ST_TICK: begin
        cmd.tick     = 1'b1;
        cmd.addr_sel = ADDR_CUR;
        if (sts.cont) begin
          state_nxt = ST_OUT;
        end else if (sts.has_cur) begin
          state_nxt = ST_CH_RD;
        end else begin
          cmd.scan_clr = 1'b1;
          state_nxt    = ST_SCAN;
        end
      end
      ST_CH_RD: begin
        cmd.ch_start = 1'b1;
        state_nxt    = ST_CH_DIV;
      end
      ST_CH_DIV: begin
        if (!sts.div_busy) state_nxt = ST_CH_WR;
      end
      ST_CH_WR: begin
        cmd.ch_wr    = 1'b1;
        cmd.scan_clr = 1'b1;
        state_nxt    = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.addr_sel  = ADDR_SCAN;
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          if (sts.found) begin
            state_nxt = ST_MUL;
          end else begin
            cmd.res_none = 1'b1;
            state_nxt    = ST_OUT;
          end
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_GR_START;
      end
      ST_GR_START: begin
        cmd.gr_start = 1'b1;
        state_nxt    = ST_GR_DIV;
      end
      ST_GR_DIV: begin
        if (!sts.div_busy) state_nxt = ST_GRANT;
      end
      ST_GRANT: begin
        cmd.grant = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered stall.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != ST_IDLE);
    end
  end

  assign in_stall = in_stall_r;

endmodule
`default_nettype wire

// ===== rtl/fair_share_slot_scheduler.sv =====
`default_nettype none
// A table request, or a tick that keeps the current task, is applied and its item goes to the output
// register. A tick that charges the leaving task and picks a new one also runs the charge, the scan and
// the grant division, and skips the charge with no task to charge: one entry is scanned per cycle,
// and the divider runs 18 steps for the charge and 28 for the grant.
// Throughput: one item at a time; the next is taken once the result is queued.
// Reset (rst_n, synchronous): idle slots, register defaults restored, no current task.
// ----------------------------------------------------------------------------
// Fair-share slot scheduler
// Nice-weighted fair scheduler over a table of task slots, with a controller
// and a datapath.
// ----------------------------------------------------------------------------
module fair_share_slot_scheduler #(
  parameter int NUM_SLOTS = fss_pkg::NUM_SLOTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_req_type,
  input  logic [fss_pkg::SLOT_IN_W-1:0]        in_slot,
  input  logic                                 in_runnable_in,
  input  logic signed [fss_pkg::NICE_IN_W-1:0] in_nice_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_run_valid,
  output logic [fss_pkg::SLOT_IN_W-1:0]        out_run_slot,
  output logic                                 out_new_pick,
  output logic [fss_pkg::LEN_W-1:0]            out_slice_len,
  output logic signed [fss_pkg::NICE_W-1:0]    out_nice_now,
  input  logic                                 cfg_wr_en,
  input  logic [fss_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fss_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  import fss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fss_datapath #(.NUM_SLOTS(NUM_SLOTS)) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_req_type    (in_req_type),
    .in_slot        (in_slot),
    .in_runnable_in (in_runnable_in),
    .in_nice_in     (in_nice_in),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .cmd            (cmd),
    .sts            (sts),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_run_valid  (out_run_valid),
    .out_run_slot   (out_run_slot),
    .out_new_pick   (out_new_pick),
    .out_slice_len  (out_slice_len),
    .out_nice_now   (out_nice_now)
  );

endmodule
`default_nettype wire

// ===== tb/fss_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fair-share scheduler checker
// Watches the request and result channels and the register write port. It
// keeps its own copy of the slot table, works out each expected result and
// compares every field of every result with the oldest expected one.
// ----------------------------------------------------------------------------
module fss_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic [1:0]                           in_req_type,
  input  logic [fss_pkg::SLOT_IN_W-1:0]        in_slot,
  input  logic                                 in_runnable_in,
  input  logic signed [fss_pkg::NICE_IN_W-1:0] in_nice_in,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic                                 out_run_valid,
  input  logic [fss_pkg::SLOT_IN_W-1:0]        out_run_slot,
  input  logic                                 out_new_pick,
  input  logic [fss_pkg::LEN_W-1:0]            out_slice_len,
  input  logic signed [fss_pkg::NICE_W-1:0]    out_nice_now,
  input  logic                                 cfg_wr_en,
  input  logic [fss_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fss_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  output int                                   fail_count,
  output int                                   pending,
  output int                                   picks_seen
);

  import fss_pkg::*;

  localparam int SLOTS = 64;
  localparam logic [VR_W-1:0] VR_TOP = {VR_W{1'b1}};

  typedef struct packed {
    logic                     run_valid;
    logic [SLOT_IN_W-1:0]     run_slot;
    logic                     new_pick;
    logic [LEN_W-1:0]         slice_len;
    logic signed [NICE_W-1:0] nice_now;
  } sched_result_t;

  // Nice-to-weight table, 1024 at nice 0.
  localparam int unsigned NICE_WEIGHT [40] = '{
    88761, 71755, 56483, 46273, 36291, 29154, 23254, 18705, 14949, 11916,
    9548, 7620, 6100, 4904, 3906, 3121, 2501, 1991, 1586, 1277,
    1024, 820, 655, 526, 423, 335, 272, 215, 172, 137,
    110, 87, 70, 56, 45, 36, 29, 23, 18, 15
  };

  sched_result_t       expected_q[$];
  logic [LAT_W-1:0]    lat_reg;
  logic [LEN_W-1:0]    max_reg;
  logic [LEN_W-1:0]    min_reg;
  logic                slot_ready [SLOTS];
  int                  slot_nice [SLOTS];
  logic [VR_W-1:0]     slot_vrt [SLOTS];
  int unsigned         cur_slot;
  logic                cur_valid;
  int unsigned         grant_len;
  int unsigned         grant_left;

  function automatic longint unsigned slot_weight(int unsigned s);
    return NICE_WEIGHT[slot_nice[s] + 20];
  endfunction

  task automatic report_mismatch(input string what, input longint got,
                                 input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // Advances the table model by one request and returns its result.
  function automatic sched_result_t schedule_request(
      input req_t req, input int unsigned s, input logic ready, input int nreq);
    sched_result_t r;
    longint unsigned used, chg, v, sum, prod, len;
    int unsigned best;
    logic found;
    r = '0;
    if (req == REQ_TICK) begin
      if (grant_left > 0) grant_left--;
      if (cur_valid && grant_left > 0 && slot_ready[cur_slot]) begin
        r.run_valid = 1'b1;
        r.run_slot  = cur_slot[SLOT_IN_W-1:0];
        r.slice_len = grant_len[LEN_W-1:0];
      end else begin
        // The leaving task is charged exactly once.
        if (cur_valid) begin
          used = grant_len - grant_left;
          chg  = used * 1024 / slot_weight(cur_slot);
          if (chg < 1) chg = 1;
          v = longint'(slot_vrt[cur_slot]) + chg;
          if (v > VR_TOP) v = VR_TOP;
          slot_vrt[cur_slot] = v[VR_W-1:0];
          cur_valid = 1'b0;
        end
        found = 1'b0;
        best = 0;
        sum = 0;
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_ready[i]) begin
            sum += slot_weight(i);
            if (!found || slot_vrt[i] < slot_vrt[best]) begin
              best = i;
              found = 1'b1;
            end
          end
        end
        if (found) begin
          prod = longint'(lat_reg) * slot_weight(best);
          len = (prod + sum - 1) / sum;
          if (len > max_reg) len = max_reg;
          if (len < min_reg) len = min_reg;
          cur_slot = best;
          cur_valid = 1'b1;
          grant_len = 32'(len);
          grant_left = 32'(len);
          r.run_valid = 1'b1;
          r.run_slot  = best[SLOT_IN_W-1:0];
          r.new_pick  = 1'b1;
          r.slice_len = len[LEN_W-1:0];
        end
      end
    end else begin
      case (req)
        REQ_RUNNABLE: slot_ready[s] = ready;
        REQ_NICE: if (nreq >= -20 && nreq <= 19) slot_nice[s] = nreq;
        default: begin
          slot_ready[s] = 1'b0;
          slot_nice[s] = 0;
          slot_vrt[s] = '0;
          if (cur_valid && cur_slot == s) begin
            cur_valid = 1'b0;
            grant_left = 0;
          end
        end
      endcase
      r.nice_now = slot_nice[s][NICE_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    sched_result_t want, got;
    if (!rst_n) begin
      lat_reg = 10'd100;
      max_reg = 8'd10;
      min_reg = 8'd1;
      for (int i = 0; i < SLOTS; i++) begin
        slot_ready[i] = 1'b0;
        slot_nice[i] = 0;
        slot_vrt[i] = '0;
      end
      cur_slot = 0;
      cur_valid = 1'b0;
      grant_len = 0;
      grant_left = 0;
      expected_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_LATENCY: lat_reg = cfg_wdata[LAT_W-1:0];
          CFG_MAX:     max_reg = cfg_wdata[LEN_W-1:0];
          CFG_MIN:     min_reg = cfg_wdata[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_q.push_back(schedule_request(req_t'(in_req_type), in_slot,
                                              in_runnable_in, int'(in_nice_in)));
      if (out_valid && !out_stall) begin
        got = '{out_run_valid, out_run_slot, out_new_pick, out_slice_len, out_nice_now};
        if (expected_q.size() == 0) begin
          report_mismatch("result count", 1, 0);
        end else begin
          want = expected_q.pop_front();
          if (got.new_pick) picks_seen++;
          if (got.run_valid !== want.run_valid)
            report_mismatch("run_valid", got.run_valid, want.run_valid);
          if (got.run_slot !== want.run_slot)
            report_mismatch("run_slot", got.run_slot, want.run_slot);
          if (got.new_pick !== want.new_pick)
            report_mismatch("new_pick", got.new_pick, want.new_pick);
          if (got.slice_len !== want.slice_len)
            report_mismatch("slice_len", got.slice_len, want.slice_len);
          if (got.nice_now !== want.nice_now)
            report_mismatch("nice_now", got.nice_now, want.nice_now);
        end
      end
    end
    pending = expected_q.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
    picks_seen = 0;
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fair-share scheduler testbench
// Drives directed and random request streams through several register
// settings with bursty input and a stalling receiver; the checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  import fss_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic [1:0]                  in_req_type;
  logic [SLOT_IN_W-1:0]        in_slot;
  logic                        in_runnable_in;
  logic signed [NICE_IN_W-1:0] in_nice_in;
  logic                        out_valid;
  logic                        out_stall;
  logic                        out_run_valid;
  logic [SLOT_IN_W-1:0]        out_run_slot;
  logic                        out_new_pick;
  logic [LEN_W-1:0]            out_slice_len;
  logic signed [NICE_W-1:0]    out_nice_now;
  logic                        cfg_wr_en;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [CFG_DATA_W-1:0]       cfg_wdata;
  int                          fail_count;
  int                          pending;
  int                          picks_seen;
  int                          items_sent;
  int                          idle_cycles;
  logic                        hold_off;

  fair_share_slot_scheduler DUT (.*);

  fss_checker u_checker (.*);

  // Clock: 12 ns period.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Receiver stall pattern, with a long hold-off on request.
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (($time / 3000) % 3 == 0) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Offers one item and waits until it is accepted.
  task automatic send_request(input req_t req, input int s, input logic ready,
                              input int nv);
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_slot        <= s[SLOT_IN_W-1:0];
    in_runnable_in <= ready;
    in_nice_in     <= nv[NICE_IN_W-1:0];
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic idle_gap(input int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Waits for all results, then past any tick still in flight.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  // Random phase: mostly runnable slots and ticks, some noise.
  task automatic random_phase(input int count, input int top_slot);
    int k, burst;
    k = 0;
    while (k < count) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && k < count; b++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: send_request(REQ_TICK, $urandom, 1'($urandom), $urandom);
          4, 5: send_request(REQ_RUNNABLE, $urandom_range(0, top_slot),
                             ($urandom_range(0, 3) != 0), $urandom);
          6, 7: send_request(REQ_NICE, $urandom_range(0, top_slot), 1'($urandom),
                             ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 255))
                                                          : int'($urandom_range(0, 39)) - 20);
          8: send_request(REQ_CLEAR, $urandom_range(0, top_slot), 1'($urandom), $urandom);
          default: send_request(REQ_TICK, $urandom_range(0, 63), 1'b0, 0);
        endcase
        k++;
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 8));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_TICK;
    in_slot = '0;
    in_runnable_in = 1'b0;
    in_nice_in = '0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_LATENCY;
    cfg_wdata = '0;
    hold_off = 1'b0;
    items_sent = 0;
    idle_cycles = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty tick, nice extremes, ticks, clear of a runnable slot.
    send_request(REQ_TICK, 0, 1'b0, 0);
    send_request(REQ_NICE, 0, 1'b0, -20);
    send_request(REQ_NICE, 63, 1'b0, 19);
    send_request(REQ_NICE, 5, 1'b0, -128);
    send_request(REQ_NICE, 5, 1'b0, 127);
    send_request(REQ_NICE, 6, 1'b0, -21);
    send_request(REQ_NICE, 6, 1'b0, 20);
    send_request(REQ_RUNNABLE, 0, 1'b1, 0);
    send_request(REQ_RUNNABLE, 63, 1'b1, 0);
    send_request(REQ_RUNNABLE, 7, 1'b1, 0);
    for (int i = 0; i < 6; i++) send_request(REQ_TICK, 0, 1'b0, 0);
    send_request(REQ_RUNNABLE, 0, 1'b0, 0);
    send_request(REQ_TICK, 0, 1'b0, 0);
    send_request(REQ_CLEAR, 63, 1'b1, -1);
    send_request(REQ_TICK, 0, 1'b0, 0);
    send_request(REQ_TICK, 0, 1'b0, 0);
    drain();

    // Register extremes, including min above max and zero clamps.
    write_reg(CFG_LATENCY, 1023);
    write_reg(CFG_MAX, 255);
    write_reg(CFG_MIN, 1);
    random_phase(250, 63);
    drain();
    write_reg(CFG_LATENCY, 1);
    write_reg(CFG_MAX, 1);
    write_reg(CFG_MIN, 255);
    random_phase(200, 7);
    drain();
    write_reg(CFG_MAX, 0);
    write_reg(CFG_MIN, 0);
    random_phase(150, 3);
    drain();

    // Long receiver hold-off while items keep coming.
    write_reg(CFG_LATENCY, $urandom_range(1, 1023));
    write_reg(CFG_MAX, $urandom_range(1, 255));
    write_reg(CFG_MIN, $urandom_range(1, 8));
    hold_off = 1'b1;
    fork
      random_phase(20, 15);
      begin
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
    join
    random_phase(480, 15);
    drain();

    $display("tb_top: %0d requests sent, %0d new picks checked, over five register",
             items_sent, picks_seen);
    $display("tb_top: settings including clamp extremes and a long receiver hold-off");
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
